// File: rtl/core/eset_pkg.sv
// ----------------------------------------------------------------------------
// eset_pkg
// Shared types and constants for the encoder sector speed tracker.
// ----------------------------------------------------------------------------
package eset_pkg;

    localparam int SECTORS_DEF   = 64;
    localparam int MAX_REVS_DEF  = 8;
    localparam int TIME_BITS_DEF = 48;

    // 60e6 * 2^16 and round(2*pi * 1e6 * 2^16)
    localparam int K_W = 42;
    localparam logic [K_W-1:0] K_RPM  = 42'd3932160000000;
    localparam logic [K_W-1:0] K_RADS = 42'd411774832291;

    localparam int PCT_W = 10;
    localparam logic [PCT_W-1:0] PCT_UNITY = 10'd100;

    localparam int TAB_AW    = 7;
    localparam int TAB_DEPTH = 1 << TAB_AW;

    localparam int Q_W = 32;

    typedef enum logic [2:0] {
        FN_PULSE    = 3'd0,
        FN_INDEX    = 3'd1,
        FN_SET_DIR  = 3'd2,
        FN_VEL_RST  = 3'd3,
        FN_VEL_EN   = 3'd4,
        FN_CAL_REQ  = 3'd5,
        FN_TAB_WR   = 3'd6
    } t_func;

    typedef enum logic [0:0] {
        CFG_SPEED_UNIT = 1'b0,
        CFG_USE_CORR   = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_PREP,
        S_DIV,
        S_DONE
    } t_state;

endpackage

// File: rtl/core/eset_div.sv
// ----------------------------------------------------------------------------
// eset_div
// Bit-serial restoring divider, one quotient bit per cycle, 32-bit saturated.
// ----------------------------------------------------------------------------
module eset_div import eset_pkg::*; #(
    parameter int NUM_W = 53,
    parameter int DEN_W = 49
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [Q_W-1:0]   o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [Q_W-1:0]   r_quo;
    logic             r_sat;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_num[NUM_W-1]};
        ge    = trial >= {1'b0, r_den};
        n_rem = ge ? DEN_W'(trial - {1'b0, r_den}) : DEN_W'(trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
            r_sat <= 1'b0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_quo <= {r_quo[Q_W-2:0], ge};
            r_sat <= r_sat | r_quo[Q_W-1];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_sat ? '1 : r_quo;

endmodule

// File: rtl/core/encoder_sector_speed_tracker.sv
// ----------------------------------------------------------------------------
// encoder_sector_speed_tracker
// Period-measurement speed tracker with sector count, calibration capture
// and a per-sector, per-direction correction table.
// ----------------------------------------------------------------------------
//
//  channel   signals                          direction  notes
//  -------   -------------------------------  ---------  ----------------------
//  command   i_valid/o_ready, i_func..        in         one command per txn
//  result    o_valid/i_ready, o_sector..      out        one result per command
//  config    i_cfg_we, i_cfg_index, i_cfg_data in        write only, no wait
//
//  Sequence: tracker state updates on the accept edge. Speed then takes a
//  table read (S_READ), a multiply (S_PREP), the bit-serial divider (S_DIV)
//  and a load (S_DONE) per transaction, from accept to the next accept;
//  S_PREP and S_DIV are skipped when speed is forced to zero (held or no
//  interval).
//  Reset: synchronous, clears the tracker state (not the capture fields)
//  and the table valid bits; unwritten table entries read as 100 percent.
//  No clearing pass. Stalls: the next command is accepted while a result
//  waits; the finished result of that command waits in S_DONE until the output register frees.
//
module encoder_sector_speed_tracker import eset_pkg::*; #(
    parameter int SECTORS   = SECTORS_DEF,
    parameter int MAX_REVS  = MAX_REVS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0]           i_func,
    input  logic [TIME_BITS-1:0] i_time_us,
    input  logic                 i_dir_value,
    input  logic [5:0]           i_table_sector,
    input  logic                 i_table_dir,
    input  logic [PCT_W-1:0]     i_table_percent,
    // result channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [5:0]           o_sector,
    output logic [31:0]          o_interval_us,
    output logic [31:0]          o_speed_q16,
    output logic                 o_calibrating,
    output logic [3:0]           o_revs_done,
    output logic                 o_capture_valid,
    output logic [5:0]           o_capture_sector,
    output logic [2:0]           o_capture_rev,
    // configuration
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic                 i_cfg_data
);

    localparam int SEC_W    = (SECTORS > 1) ? $clog2(SECTORS) : 1;
    localparam int REV_W    = $clog2(MAX_REVS + 1);
    localparam int DEN_MULT = SECTORS * 100;
    localparam int DEN_W    = 32 + $clog2(DEN_MULT + 1);
    localparam int NUM_W    = ((DEN_W > K_W + PCT_W) ? DEN_W : (K_W + PCT_W)) + 1;

    localparam logic [SEC_W-1:0]     SEC_LAST = SEC_W'(SECTORS - 1);
    localparam logic [REV_W-1:0]     REV_MAX  = REV_W'(MAX_REVS);
    localparam logic [TIME_BITS-1:0] IVL_MAX  = TIME_BITS'(33'h0_FFFF_FFFF);

    // ---------------- configuration ----------------
    logic r_speed_unit;
    logic r_use_corr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_unit <= 1'b0;
            r_use_corr   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SPEED_UNIT: r_speed_unit <= i_cfg_data;
                CFG_USE_CORR:   r_use_corr   <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // ---------------- tracker state ----------------
    logic [TIME_BITS-1:0] r_last_time, n_last_time;
    logic [31:0]          r_interval, n_interval;
    logic [SEC_W-1:0]     r_sec, n_sec;
    logic                 r_dir, n_dir;
    logic                 r_held, n_held;
    logic                 r_cal_req, n_cal_req;
    logic                 r_cal_act, n_cal_act;
    logic [REV_W-1:0]     r_revs, n_revs;
    logic                 n_cap_valid;
    logic [SEC_W-1:0]     n_cap_sec;
    logic [REV_W-1:0]     n_cap_rev;

    logic                 r_cap_valid;
    logic [SEC_W-1:0]     r_cap_sec;
    logic [REV_W-1:0]     r_cap_rev;

    logic                 accept;
    logic [TIME_BITS-1:0] diff;

    assign accept = i_valid && o_ready;
    assign diff   = i_time_us - r_last_time;

    always_comb begin
        n_last_time = r_last_time;
        n_interval  = r_interval;
        n_sec       = r_sec;
        n_dir       = r_dir;
        n_held      = r_held;
        n_cal_req   = r_cal_req;
        n_cal_act   = r_cal_act;
        n_revs      = r_revs;
        n_cap_valid = 1'b0;
        n_cap_sec   = '0;
        n_cap_rev   = '0;
        unique case (i_func)
            FN_PULSE: begin
                if (r_last_time != '0) begin
                    n_interval = (diff > IVL_MAX) ? 32'hFFFF_FFFF : 32'(diff);
                    if (r_cal_act && r_revs < REV_MAX) begin
                        n_cap_valid = 1'b1;
                        n_cap_sec   = r_sec;
                        n_cap_rev   = r_revs;
                    end
                end
                n_last_time = i_time_us;
                n_sec       = (r_sec == SEC_LAST) ? '0 : r_sec + 1'b1;
            end
            FN_INDEX: begin
                n_sec = '0;
                if (r_cal_req && !r_cal_act) begin
                    n_cal_act = 1'b1;
                    n_cal_req = 1'b0;
                    n_revs    = '0;
                end else if (r_cal_act && r_revs < REV_MAX) begin
                    n_revs = r_revs + 1'b1;
                end
            end
            FN_SET_DIR: begin
                n_dir = i_dir_value;
                n_sec = SEC_LAST - r_sec;
            end
            FN_VEL_RST: begin
                n_held      = 1'b1;
                n_interval  = '0;
                n_last_time = '0;
            end
            FN_VEL_EN:  n_held    = 1'b0;
            FN_CAL_REQ: n_cal_req = 1'b1;
            FN_TAB_WR:  ;
            default:    ;   // unused code: no state change
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
            r_interval  <= '0;
            r_sec       <= '0;
            r_dir       <= 1'b0;
            r_held      <= 1'b0;
            r_cal_req   <= 1'b0;
            r_cal_act   <= 1'b0;
            r_revs      <= '0;
        end else if (accept) begin
            r_last_time <= n_last_time;
            r_interval  <= n_interval;
            r_sec       <= n_sec;
            r_dir       <= n_dir;
            r_held      <= n_held;
            r_cal_req   <= n_cal_req;
            r_cal_act   <= n_cal_act;
            r_revs      <= n_revs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cap_valid <= n_cap_valid;
            r_cap_sec   <= n_cap_sec;
            r_cap_rev   <= n_cap_rev;
        end
    end

    // ---------------- correction table ----------------
    // Valid bit per entry; an entry never written reads as 100 percent.
    logic [PCT_W-1:0]     r_table [TAB_DEPTH];
    logic [TAB_DEPTH-1:0] r_tab_vld;
    logic [PCT_W-1:0]     r_tab_q;
    logic                 r_tab_hit;
    logic [TAB_AW-1:0]    wr_addr;
    logic [TAB_AW-1:0]    rd_addr;
    logic [SEC_W-1:0]     prev_sec;
    logic                 tab_we;

    assign tab_we   = accept && (i_func == FN_TAB_WR);
    assign wr_addr  = {i_table_sector, i_table_dir};
    assign prev_sec = (r_sec == '0) ? SEC_LAST : r_sec - 1'b1;
    assign rd_addr  = {6'(prev_sec), r_dir};

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_table[wr_addr] <= i_table_percent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_vld <= '0;
        end else if (tab_we) begin
            r_tab_vld[wr_addr] <= 1'b1;
        end
    end

    // ---------------- sequencer ----------------
    t_state r_state, n_state;
    logic   st_read, st_prep, st_load;
    logic   div_done;
    logic [Q_W-1:0] div_quo;

    always_ff @(posedge i_clk) begin
        if (st_read) begin
            r_tab_q   <= r_table[rd_addr];
            r_tab_hit <= r_tab_vld[rd_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_READ;
            S_READ: n_state = (r_held || r_interval == '0) ? S_DONE : S_PREP;
            S_PREP: n_state = S_DIV;
            S_DIV:  if (div_done) n_state = S_DONE;
            S_DONE: if (!o_valid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == S_IDLE);
        st_read = (r_state == S_READ);
        st_prep = (r_state == S_PREP);
        st_load = (r_state == S_DONE) && (!o_valid || i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- speed datapath ----------------
    logic [DEN_W-1:0] r_den;
    logic             r_zero;
    logic [PCT_W-1:0] pct;
    logic [K_W-1:0]   kval;
    logic [NUM_W-1:0] num;

    always_ff @(posedge i_clk) begin
        if (st_read) begin
            r_den  <= DEN_W'(r_interval) * DEN_W'(DEN_MULT);
            r_zero <= r_held || (r_interval == '0);
        end
    end

    // Product is K_W + PCT_W bits wide; widen operands before the multiply.
    always_comb begin
        pct  = (r_use_corr && r_tab_hit) ? r_tab_q : PCT_UNITY;
        kval = r_speed_unit ? K_RADS : K_RPM;
        num  = NUM_W'(kval) * NUM_W'(pct) + NUM_W'(r_den >> 1);
    end

    eset_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (st_prep),
        .i_num   (num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // ---------------- result register ----------------
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (st_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_load) begin
            o_sector         <= 6'(r_sec);
            o_interval_us    <= r_interval;
            o_speed_q16      <= r_zero ? '0 : div_quo;
            o_calibrating    <= r_cal_act;
            o_revs_done      <= 4'(r_revs);
            o_capture_valid  <= r_cap_valid;
            o_capture_sector <= 6'(r_cap_sec);
            o_capture_rev    <= 3'(r_cap_rev);
        end
    end

    assign o_valid = r_out_valid;

endmodule

// File: rtl/core/eset_chk.sv
// ----------------------------------------------------------------------------
// eset_chk
// Port-level checks on the speed tracker, bound to the top level.
// ----------------------------------------------------------------------------
module eset_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_interval_us,
    input logic [31:0] o_speed_q16,
    input logic        o_calibrating,
    input logic        o_capture_valid,
    input logic [5:0]  o_capture_sector,
    input logic [2:0]  o_capture_rev
);

    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_speed_q16))
        else $error("stalled result changed");

    a_speed_ivl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_speed_q16 != 32'd0 |-> o_interval_us != 32'd0)
        else $error("speed without interval");

    a_cap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_capture_valid |-> o_capture_sector == 6'd0 && o_capture_rev == 3'd0)
        else $error("capture fields set without capture");

    a_cap_cal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_capture_valid |-> o_calibrating)
        else $error("capture while not calibrating");

endmodule

bind encoder_sector_speed_tracker eset_chk u_eset_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_interval_us    (o_interval_us),
    .o_speed_q16      (o_speed_q16),
    .o_calibrating    (o_calibrating),
    .o_capture_valid  (o_capture_valid),
    .o_capture_sector (o_capture_sector),
    .o_capture_rev    (o_capture_rev)
);
